// ===== hdl/hcb_pkg.sv =====
// ----------------------------------------------------------------------------
// hcb_pkg
// Shared constants and types of the Huffman code builder.
// ----------------------------------------------------------------------------
package hcb_pkg;

  // Alphabet and arithmetic sizes.
  localparam int ALPHABET     = 256;
  localparam int SYM_BITS     = 8;
  localparam int COUNT_BITS   = 20;
  localparam int MAX_CODE_LEN = 32;
  localparam int CODE_BITS    = MAX_CODE_LEN;
  localparam int LEN_BITS     = $clog2(MAX_CODE_LEN + 1);
  localparam int NODE_MAX     = 2 * ALPHABET - 1;
  localparam int NODE_BITS    = $clog2(NODE_MAX);
  localparam int ACT_BITS     = $clog2(ALPHABET);
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);

  // Operation codes on the input channel.
  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // Item classes handed from the front to the back.
  typedef enum logic [1:0] {
    K_ADD,
    K_BUILD,
    K_LOOKUP
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic [SYM_BITS-1:0]  symbol;
  } cmd_t;

  // Back-end sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD,
    S_BLD_INIT,
    S_SCAN,
    S_FIND,
    S_MERGE,
    S_MV_RD,
    S_MV_WR,
    S_WALK_INIT,
    S_WALK_RD,
    S_WALK_W0,
    S_WALK_W1,
    S_LEAF_RD,
    S_LEAF_WR,
    S_LOOK
  } state_t;

endpackage

// ===== hdl/hcb_if.sv =====
// ----------------------------------------------------------------------------
// hcb_if
// Valid/ready channels of the Huffman code builder.
// ----------------------------------------------------------------------------
interface hcb_in_if;
  import hcb_pkg::*;
  logic                valid;
  logic                ready;
  logic                op;
  logic [SYM_BITS-1:0] symbol;
  logic                last;
  modport source (output valid, op, symbol, last, input ready);
  modport sink (input valid, op, symbol, last, output ready);
endinterface

interface hcb_out_if;
  import hcb_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CODE_BITS-1:0] code;
  logic [LEN_BITS-1:0]  code_length;
  logic                 present;
  logic                 overflow;
  modport source (output valid, code, code_length, present, overflow, input ready);
  modport sink (input valid, code, code_length, present, overflow, output ready);
endinterface

// ===== hdl/hcb_front.sv =====
// ----------------------------------------------------------------------------
// hcb_front
// Accepts input items, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module hcb_front (
  input  logic           clk,
  input  logic           rst_n,
  hcb_in_if.sink         in_chan,
  output hcb_pkg::cmd_t  cmd,
  output logic           cmd_valid,
  input  logic           cmd_pop
);
  import hcb_pkg::*;

  cmd_t                 q_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wp_r;
  logic [QPTR_BITS-1:0] rp_r;
  logic [QPTR_BITS:0]   cnt_r;
  cmd_t                 in_cmd;
  logic                 push;
  logic                 pop;

  // Classify the incoming item.
  always_comb begin
    in_cmd.symbol = in_chan.symbol;
    if (in_chan.op == OP_LOOKUP) begin
      in_cmd.kind = K_LOOKUP;
    end else if (in_chan.last) begin
      in_cmd.kind = K_BUILD;
    end else begin
      in_cmd.kind = K_ADD;
    end
  end

  assign in_chan.ready = (cnt_r < (QPTR_BITS + 1)'(QUEUE_DEPTH));
  assign push          = in_chan.valid && in_chan.ready;
  assign cmd_valid     = (cnt_r != '0);
  assign pop           = cmd_pop && cmd_valid;
  assign cmd           = q_r[rp_r];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= in_cmd;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (QPTR_BITS + 1)'(push) - (QPTR_BITS + 1)'(pop);
    end
  end

endmodule

// ===== hdl/hcb_back.sv =====
// ----------------------------------------------------------------------------
// hcb_back
// Histogram, tree build, code table and lookup result register.
// ----------------------------------------------------------------------------
module hcb_back (
  input  logic           clk,
  input  logic           rst_n,
  input  hcb_pkg::cmd_t  cmd,
  input  logic           cmd_valid,
  output logic           cmd_pop,
  hcb_out_if.source      out_chan
);
  import hcb_pkg::*;

  typedef struct packed {
    logic [COUNT_BITS-1:0] w;
    logic [SYM_BITS-1:0]   key;
    logic [NODE_BITS-1:0]  node;
  } act_t;

  typedef struct packed {
    logic [NODE_BITS-1:0] zero;
    logic [NODE_BITS-1:0] one;
  } kid_t;

  typedef struct packed {
    logic [CODE_BITS-1:0] code;
    logic [LEN_BITS-1:0]  len;
  } walk_t;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  function automatic logic ranks_below(input act_t a, input act_t b);
    ranks_below = (a.w < b.w) || ((a.w == b.w) && (a.key < b.key));
  endfunction

  function automatic walk_t give(input walk_t p, input logic b);
    walk_t c;
    if (p.len < LEN_BITS'(MAX_CODE_LEN)) begin
      c.code = {p.code[CODE_BITS-2:0], b};
      c.len  = p.len + 1'b1;
    end else begin
      c = p;
    end
    give = c;
  endfunction

  // Memories.
  logic [COUNT_BITS-1:0] cnt_mem  [ALPHABET];
  act_t                  act_mem  [ALPHABET];
  logic [SYM_BITS-1:0]   leaf_mem [ALPHABET];
  kid_t                  kid_mem  [ALPHABET];
  walk_t                 walk_mem [NODE_MAX];
  walk_t                 tbl_mem  [ALPHABET];

  logic [COUNT_BITS-1:0] cnt_rd_r;
  act_t                  act_rd_r;
  logic [SYM_BITS-1:0]   leaf_rd_r;
  kid_t                  kid_rd_r;
  walk_t                 walk_rd_r;
  walk_t                 tbl_rd_r;

  // Memory controls.
  logic [ACT_BITS-1:0]   cnt_raddr, cnt_waddr;
  logic                  cnt_we;
  logic [COUNT_BITS-1:0] cnt_wdata;
  logic [ACT_BITS-1:0]   act_raddr, act_waddr;
  logic                  act_we;
  act_t                  act_wdata;
  logic [ACT_BITS-1:0]   leaf_raddr;
  logic                  leaf_we;
  logic [ACT_BITS-1:0]   kid_raddr, kid_waddr;
  logic                  kid_we;
  kid_t                  kid_wdata;
  logic [NODE_BITS-1:0]  walk_raddr, walk_waddr;
  logic                  walk_we;
  walk_t                 walk_wdata;
  logic [ACT_BITS-1:0]   tbl_raddr;
  logic                  tbl_we;

  // Control and status registers.
  state_t                state_r, state_nxt;
  kind_t                 kind_r;
  logic [SYM_BITS-1:0]   sym_r;
  logic [ALPHABET-1:0]   cnt_vld_r;
  logic [ALPHABET-1:0]   present_r;
  logic [COUNT_BITS-1:0] total_r;
  logic                  lenx_r;
  logic                  clr_r;
  logic                  tovf_r;
  logic [ACT_BITS:0]     idx_r;
  logic                  rvld_r;
  logic [ACT_BITS-1:0]   ridx_r;
  logic [ACT_BITS:0]     leaves_r;
  logic [ACT_BITS:0]     live_r;
  logic [NODE_BITS-1:0]  next_r;
  logic [ACT_BITS:0]     k_r;
  logic                  fvld_r;
  logic [ACT_BITS-1:0]   fidx_r;
  act_t                  b1_r, b2_r;
  logic [ACT_BITS-1:0]   b1i_r, b2i_r;
  logic                  b1v_r, b2v_r;
  logic [ACT_BITS-1:0]   hi_r;
  logic [NODE_BITS-1:0]  p_r;
  logic [ACT_BITS:0]     i_r;

  // Output register.
  logic                  ovld_r;
  logic [CODE_BITS-1:0]  ocode_r;
  logic [LEN_BITS-1:0]   olen_r;
  logic                  opres_r;
  logic                  oovf_r;

  // Derived terms.
  logic                  sym_ok;
  logic [COUNT_BITS-1:0] add_old;
  logic [COUNT_BITS-1:0] add_tot;
  logic                  add_full;
  logic                  scan_done;
  logic                  find_done;
  logic [COUNT_BITS-1:0] scan_cnt;
  act_t                  zero_n, one_n;
  logic [ACT_BITS-1:0]   lo_i, hi_i;
  logic [ACT_BITS-1:0]   live_last;
  logic                  out_free;
  logic                  lk_pres;

  assign sym_ok    = ({1'b0, sym_r} < (SYM_BITS + 1)'(ALPHABET));
  assign add_old   = (clr_r || !cnt_vld_r[sym_r[ACT_BITS-1:0]]) ? '0 : cnt_rd_r;
  assign add_tot   = clr_r ? '0 : total_r;
  assign add_full  = (add_tot >= COUNT_MAX);
  assign scan_done = (idx_r == (ACT_BITS + 1)'(ALPHABET)) && !rvld_r;
  assign find_done = (k_r == live_r) && !fvld_r;
  assign scan_cnt  = cnt_vld_r[ridx_r] ? cnt_rd_r : '0;
  assign live_last = ACT_BITS'(live_r - 1'b1);
  assign out_free  = !ovld_r || out_chan.ready;
  assign lk_pres   = sym_ok && present_r[sym_r[ACT_BITS-1:0]];
  assign cmd_pop   = (state_r == S_IDLE) && cmd_valid;

  // Pick the 0 and 1 branches of the merge.
  always_comb begin
    if (b1_r.w != b2_r.w) begin
      zero_n = b2_r;
      one_n  = b1_r;
    end else begin
      zero_n = b1_r;
      one_n  = b2_r;
    end
    if (b1i_r < b2i_r) begin
      lo_i = b1i_r;
      hi_i = b2i_r;
    end else begin
      lo_i = b2i_r;
      hi_i = b1i_r;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          state_nxt = (cmd.kind == K_LOOKUP) ? S_LOOK : S_ADD;
        end
      end
      S_ADD:      state_nxt = (kind_r == K_BUILD) ? S_BLD_INIT : S_IDLE;
      S_BLD_INIT: state_nxt = S_SCAN;
      S_SCAN: begin
        if (scan_done) begin
          if (leaves_r == '0) begin
            state_nxt = S_IDLE;
          end else if (leaves_r == (ACT_BITS + 1)'(1)) begin
            state_nxt = S_WALK_INIT;
          end else begin
            state_nxt = S_FIND;
          end
        end
      end
      S_FIND: begin
        if (find_done) begin
          state_nxt = S_MERGE;
        end
      end
      S_MERGE: begin
        if (hi_i != live_last) begin
          state_nxt = S_MV_RD;
        end else begin
          state_nxt = (live_r == (ACT_BITS + 1)'(2)) ? S_WALK_INIT : S_FIND;
        end
      end
      S_MV_RD: state_nxt = S_MV_WR;
      S_MV_WR: state_nxt = (live_r == (ACT_BITS + 1)'(2)) ? S_WALK_INIT : S_FIND;
      S_WALK_INIT: begin
        state_nxt = ((next_r - 1'b1) >= NODE_BITS'(leaves_r)) ? S_WALK_RD : S_LEAF_RD;
      end
      S_WALK_RD: state_nxt = S_WALK_W0;
      S_WALK_W0: state_nxt = S_WALK_W1;
      S_WALK_W1: state_nxt = (p_r == NODE_BITS'(leaves_r)) ? S_LEAF_RD : S_WALK_RD;
      S_LEAF_RD: state_nxt = S_LEAF_WR;
      S_LEAF_WR: state_nxt = ((i_r + 1'b1) == leaves_r) ? S_IDLE : S_LEAF_RD;
      S_LOOK: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Memory controls per state.
  always_comb begin
    cnt_raddr  = (state_r == S_IDLE) ? cmd.symbol[ACT_BITS-1:0] : idx_r[ACT_BITS-1:0];
    cnt_we     = (state_r == S_ADD) && sym_ok && !add_full;
    cnt_waddr  = sym_r[ACT_BITS-1:0];
    cnt_wdata  = add_old + 1'b1;
    act_raddr  = (state_r == S_MV_RD) ? live_last : k_r[ACT_BITS-1:0];
    act_we     = 1'b0;
    act_waddr  = leaves_r[ACT_BITS-1:0];
    act_wdata  = '{w: scan_cnt, key: SYM_BITS'(ridx_r), node: NODE_BITS'(leaves_r)};
    leaf_raddr = i_r[ACT_BITS-1:0];
    leaf_we    = 1'b0;
    kid_raddr  = ACT_BITS'(p_r - NODE_BITS'(leaves_r));
    kid_we     = 1'b0;
    kid_waddr  = ACT_BITS'(next_r - NODE_BITS'(leaves_r));
    kid_wdata  = '{zero: zero_n.node, one: one_n.node};
    walk_raddr = (state_r == S_LEAF_RD) ? NODE_BITS'(i_r) : p_r;
    walk_we    = 1'b0;
    walk_waddr = kid_rd_r.zero;
    walk_wdata = give(walk_rd_r, 1'b0);
    tbl_raddr  = (state_r == S_IDLE) ? cmd.symbol[ACT_BITS-1:0] : sym_r[ACT_BITS-1:0];
    tbl_we     = 1'b0;
    case (state_r)
      S_SCAN: begin
        act_we  = rvld_r && (scan_cnt != '0);
        leaf_we = act_we;
      end
      S_MERGE: begin
        act_we    = 1'b1;
        act_waddr = lo_i;
        act_wdata = '{w: COUNT_BITS'(b1_r.w + b2_r.w), key: zero_n.key, node: next_r};
        kid_we    = 1'b1;
      end
      S_MV_WR: begin
        act_we    = 1'b1;
        act_waddr = hi_r;
        act_wdata = act_rd_r;
      end
      S_WALK_INIT: begin
        walk_we    = 1'b1;
        walk_waddr = next_r - 1'b1;
        walk_wdata = '0;
      end
      S_WALK_W0: begin
        walk_we = 1'b1;
      end
      S_WALK_W1: begin
        walk_we    = 1'b1;
        walk_waddr = kid_rd_r.one;
        walk_wdata = give(walk_rd_r, 1'b1);
      end
      S_LEAF_WR: begin
        tbl_we = 1'b1;
      end
      default: begin
        act_we = 1'b0;
      end
    endcase
  end

  // Memory arrays with registered reads.
  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    cnt_rd_r <= cnt_mem[cnt_raddr];
    if (act_we) act_mem[act_waddr] <= act_wdata;
    act_rd_r <= act_mem[act_raddr];
    if (leaf_we) leaf_mem[leaves_r[ACT_BITS-1:0]] <= SYM_BITS'(ridx_r);
    leaf_rd_r <= leaf_mem[leaf_raddr];
    if (kid_we) kid_mem[kid_waddr] <= kid_wdata;
    kid_rd_r <= kid_mem[kid_raddr];
    if (walk_we) walk_mem[walk_waddr] <= walk_wdata;
    walk_rd_r <= walk_mem[walk_raddr];
    if (tbl_we) tbl_mem[leaf_rd_r[ACT_BITS-1:0]] <= walk_rd_r;
    tbl_rd_r <= tbl_mem[tbl_raddr];
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      kind_r    <= K_ADD;
      cnt_vld_r <= '0;
      present_r <= '0;
      total_r   <= '0;
      lenx_r    <= 1'b0;
      clr_r     <= 1'b0;
      tovf_r    <= 1'b0;
      idx_r     <= '0;
      rvld_r    <= 1'b0;
      leaves_r  <= '0;
      live_r    <= '0;
      next_r    <= '0;
      k_r       <= '0;
      fvld_r    <= 1'b0;
      b1v_r     <= 1'b0;
      b2v_r     <= 1'b0;
      p_r       <= '0;
      i_r       <= '0;
      ovld_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // Latch the command.
      if (cmd_pop) begin
        kind_r <= cmd.kind;
        sym_r  <= cmd.symbol;
      end

      // Count one byte, clearing the old message first when a build is behind us.
      if (state_r == S_ADD) begin
        clr_r  <= 1'b0;
        lenx_r <= (lenx_r && !clr_r) || (sym_ok && add_full);
        if (sym_ok && !add_full) begin
          total_r <= add_tot + 1'b1;
          if (clr_r) begin
            cnt_vld_r <= ALPHABET'(1) << sym_r[ACT_BITS-1:0];
          end else begin
            cnt_vld_r[sym_r[ACT_BITS-1:0]] <= 1'b1;
          end
        end else if (clr_r) begin
          cnt_vld_r <= '0;
          total_r   <= '0;
        end
      end

      // Start of a build.
      if (state_r == S_BLD_INIT) begin
        present_r <= '0;
        tovf_r    <= lenx_r;
        clr_r     <= 1'b1;
        idx_r     <= '0;
        rvld_r    <= 1'b0;
        leaves_r  <= '0;
      end

      // Histogram scan into leaves.
      if (state_r == S_SCAN) begin
        if (idx_r != (ACT_BITS + 1)'(ALPHABET)) begin
          rvld_r <= 1'b1;
          ridx_r <= idx_r[ACT_BITS-1:0];
          idx_r  <= idx_r + 1'b1;
        end else begin
          rvld_r <= 1'b0;
        end
        if (rvld_r && (scan_cnt != '0)) begin
          leaves_r <= leaves_r + 1'b1;
        end
        if (scan_done) begin
          live_r <= leaves_r;
          next_r <= NODE_BITS'(leaves_r);
        end
      end

      // Fresh minimum search.
      if ((state_nxt == S_FIND) && (state_r != S_FIND)) begin
        k_r    <= '0;
        fvld_r <= 1'b0;
        b1v_r  <= 1'b0;
        b2v_r  <= 1'b0;
      end else if (state_r == S_FIND) begin
        if (k_r != live_r) begin
          fvld_r <= 1'b1;
          fidx_r <= k_r[ACT_BITS-1:0];
          k_r    <= k_r + 1'b1;
        end else begin
          fvld_r <= 1'b0;
        end
        if (fvld_r) begin
          if (!b1v_r || ranks_below(act_rd_r, b1_r)) begin
            b2_r  <= b1_r;
            b2i_r <= b1i_r;
            b2v_r <= b1v_r;
            b1_r  <= act_rd_r;
            b1i_r <= fidx_r;
            b1v_r <= 1'b1;
          end else if (!b2v_r || ranks_below(act_rd_r, b2_r)) begin
            b2_r  <= act_rd_r;
            b2i_r <= fidx_r;
            b2v_r <= 1'b1;
          end
        end
      end

      // Merge bookkeeping.
      if (state_r == S_MERGE) begin
        hi_r <= hi_i;
      end
      if (((state_r == S_MERGE) && (hi_i == live_last)) || (state_r == S_MV_WR)) begin
        live_r <= live_r - 1'b1;
        next_r <= next_r + 1'b1;
      end

      // Top-down walk over the internal nodes.
      if (state_r == S_WALK_INIT) begin
        p_r <= next_r - 1'b1;
        i_r <= '0;
      end
      if (state_r == S_WALK_W1) begin
        p_r <= p_r - 1'b1;
        i_r <= '0;
      end

      // Leaves into the code table.
      if (state_r == S_LEAF_WR) begin
        present_r[leaf_rd_r[ACT_BITS-1:0]] <= 1'b1;
        i_r <= i_r + 1'b1;
      end

      // Lookup result register.
      if ((state_r == S_LOOK) && out_free) begin
        ovld_r  <= 1'b1;
        ocode_r <= lk_pres ? tbl_rd_r.code : '0;
        olen_r  <= lk_pres ? tbl_rd_r.len : '0;
        opres_r <= lk_pres;
        oovf_r  <= tovf_r;
      end else if (out_chan.ready) begin
        ovld_r <= 1'b0;
      end
    end
  end

  assign out_chan.valid       = ovld_r;
  assign out_chan.code        = ocode_r;
  assign out_chan.code_length = olen_r;
  assign out_chan.present     = opres_r;
  assign out_chan.overflow    = oovf_r;

endmodule

// ===== hdl/huffman_code_builder.sv =====
// ----------------------------------------------------------------------------
// huffman_code_builder
// Byte histogram, Huffman tree build and code lookup.
// ----------------------------------------------------------------------------
// An add item is counted in a read-modify-write of the histogram. An add
// marked last then builds the tree while the back end takes no new item:
// a histogram scan, then for each of the L-1 merges (L = distinct bytes) a
// scan of the live nodes, with a move when the higher slot of the merged
// pair is not the last live one, then a walk over the internal nodes and a
// pass over the leaves to fill the code table. A lookup returns code,
// length, present and overflow; a lookup before any build returns all
// zeros. A two-item queue lets input be taken while the back end works
// and results wait.
// ----------------------------------------------------------------------------
module huffman_code_builder (
  input  logic       clk,
  input  logic       rst_n,
  hcb_in_if.sink     in_chan,
  hcb_out_if.source  out_chan
);
  import hcb_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;

  // Front end: accept and queue items.
  hcb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop)
  );

  // Back end: count, build, look up.
  hcb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .out_chan  (out_chan)
  );

endmodule

// ===== verif/huffman_code_builder_test.sv =====
// ----------------------------------------------------------------------------
// huffman_code_builder_test
// Self-checking testbench of the Huffman code builder. Messages are counted
// into the block and built into code tables, and lookups are checked against
// a software copy of the histogram, the tree merge order and the code walk.
// ----------------------------------------------------------------------------
module huffman_code_builder_test;
  import hcb_pkg::*;

  localparam int COUNT_LIMIT = (1 << COUNT_BITS) - 1;
  localparam int PEND_SLOTS  = 4096;

  typedef struct {
    logic [CODE_BITS-1:0] code;
    logic [LEN_BITS-1:0]  code_length;
    logic                 present;
    logic                 overflow;
  } code_result_t;

  logic clk;
  logic rst_n;

  hcb_in_if  in_chan ();
  hcb_out_if out_chan ();

  huffman_code_builder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Software copy of the histogram and of the last built code table.
  int unsigned          hist_count [ALPHABET];
  int unsigned          hist_total;
  bit                   hist_exceeded;
  bit                   hist_clear_due;
  bit                   table_built;
  bit                   table_overflow_flag;
  bit                   table_has [ALPHABET];
  logic [CODE_BITS-1:0] table_code [ALPHABET];
  int                   table_len [ALPHABET];

  // Tree workspace for the build.
  int unsigned          tree_weight [NODE_MAX];
  int                   tree_key [NODE_MAX];
  int                   tree_zero [NODE_MAX];
  int                   tree_one [NODE_MAX];
  int                   live_nodes [ALPHABET];
  logic [CODE_BITS-1:0] path_code [NODE_MAX];
  int                   path_len [NODE_MAX];

  // Expected results in a ring, oldest at pend_head.
  code_result_t pending_codes [PEND_SLOTS];
  int           pend_head;
  int           pend_tail;
  int           mismatch_count;
  int           long_hold;
  bit           sender_gaps;
  int           burst_left;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit.
  initial begin
    #40_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic bit node_first(int a, int b);
    if (tree_weight[a] != tree_weight[b]) return tree_weight[a] < tree_weight[b];
    return tree_key[a] < tree_key[b];
  endfunction

  // Give one child its path: at the code length cap the path stops growing.
  function automatic void extend_path(int parent, int child, logic bit_val);
    if (path_len[parent] < MAX_CODE_LEN) begin
      path_code[child] = {path_code[parent][CODE_BITS-2:0], bit_val};
      path_len[child] = path_len[parent] + 1;
    end else begin
      path_code[child] = path_code[parent];
      path_len[child] = path_len[parent];
    end
  endfunction

  // Build the tree from the histogram and fill the code table.
  function automatic void build_code_table();
    int leaves;
    int live;
    int nxt;
    int v;
    int j;
    int a;
    int b;
    int zero;
    int one;
    leaves = 0;
    for (int i = 0; i < ALPHABET; i++) begin
      table_code[i] = '0;
      table_len[i] = 0;
      table_has[i] = 1'b0;
      if (hist_count[i] != 0) begin
        tree_weight[leaves] = hist_count[i];
        tree_key[leaves] = i;
        live_nodes[leaves] = leaves;
        leaves++;
      end
    end
    table_overflow_flag = hist_exceeded;
    table_built = 1'b1;
    hist_clear_due = 1'b1;
    if (leaves == 0) return;
    live = leaves;
    nxt = leaves;
    while (live > 1) begin
      // Insertion sort of the live nodes by weight, then key.
      for (int i = 1; i < live; i++) begin
        v = live_nodes[i];
        j = i;
        while (j > 0 && node_first(v, live_nodes[j-1])) begin
          live_nodes[j] = live_nodes[j-1];
          j--;
        end
        live_nodes[j] = v;
      end
      a = live_nodes[0];
      b = live_nodes[1];
      if (tree_weight[a] != tree_weight[b] || tree_key[a] > tree_key[b]) begin
        zero = b;
        one = a;
      end else begin
        zero = a;
        one = b;
      end
      tree_weight[nxt] = (tree_weight[a] + tree_weight[b]) & COUNT_LIMIT;
      tree_key[nxt] = tree_key[zero];
      tree_zero[nxt] = zero;
      tree_one[nxt] = one;
      for (int i = 2; i < live; i++) live_nodes[i-2] = live_nodes[i];
      live_nodes[live-2] = nxt;
      live--;
      nxt++;
    end
    // Walk from the root down; parents always sit above their children.
    path_code[nxt-1] = '0;
    path_len[nxt-1] = 0;
    for (int p = nxt - 1; p >= leaves; p--) begin
      extend_path(p, tree_zero[p], 1'b0);
      extend_path(p, tree_one[p], 1'b1);
    end
    for (int i = 0; i < leaves; i++) begin
      table_code[tree_key[i]] = path_code[i];
      table_len[tree_key[i]] = path_len[i];
      table_has[tree_key[i]] = 1'b1;
    end
  endfunction

  // Update the copy for one accepted item; lookups queue their result.
  function automatic void track_item(logic op, logic [SYM_BITS-1:0] sym, logic last);
    code_result_t res;
    if (op == OP_ADD) begin
      if (hist_clear_due) begin
        foreach (hist_count[i]) hist_count[i] = 0;
        hist_total = 0;
        hist_exceeded = 1'b0;
        hist_clear_due = 1'b0;
      end
      if (hist_total >= COUNT_LIMIT) begin
        hist_exceeded = 1'b1;
      end else begin
        hist_total++;
        hist_count[sym] = (hist_count[sym] + 1) & COUNT_LIMIT;
      end
      if (last) build_code_table();
    end else begin
      res = '{code: '0, code_length: '0, present: 1'b0, overflow: 1'b0};
      if (table_built) begin
        res.overflow = table_overflow_flag;
        if (table_has[sym]) begin
          res.code = table_code[sym];
          res.code_length = LEN_BITS'(table_len[sym]);
          res.present = 1'b1;
        end
      end
      pending_codes[pend_tail % PEND_SLOTS] = res;
      pend_tail++;
    end
  endfunction

  // Send one item, with random gaps between bursts when enabled.
  task automatic send_item(logic op, logic [SYM_BITS-1:0] sym, logic last);
    if (sender_gaps && burst_left == 0) begin
      in_chan.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    in_chan.valid = 1'b1;
    in_chan.op = op;
    in_chan.symbol = sym;
    in_chan.last = last;
    do @(posedge clk); while (!in_chan.ready);
    track_item(op, sym, last);
    @(negedge clk);
  endtask

  task automatic add_byte(logic [SYM_BITS-1:0] sym, logic last = 1'b0);
    send_item(OP_ADD, sym, last);
  endtask

  task automatic lookup(logic [SYM_BITS-1:0] sym);
    send_item(OP_LOOKUP, sym, 1'b0);
  endtask

  // Pause the sender until every queued result has come back.
  task automatic drain_results();
    in_chan.valid = 1'b0;
    while (pend_head != pend_tail) @(negedge clk);
  endtask

  // Result checker.
  always @(posedge clk) begin
    code_result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pend_head == pend_tail) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: code %h length %0d present %b overflow %b",
                   out_chan.code, out_chan.code_length, out_chan.present,
                   out_chan.overflow);
      end else begin
        want = pending_codes[pend_head % PEND_SLOTS];
        pend_head++;
        if (out_chan.code !== want.code || out_chan.code_length !== want.code_length ||
            out_chan.present !== want.present || out_chan.overflow !== want.overflow) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected code %h len %0d pres %b ovf %b, got %h %0d %b %b",
                     want.code, want.code_length, want.present, want.overflow,
                     out_chan.code, out_chan.code_length, out_chan.present,
                     out_chan.overflow);
        end
      end
    end
  end

  // Receiver stalls: a long hold on request, otherwise a changing pattern.
  always @(negedge clk) begin
    int mode;
    mode = int'(($time / 512) % 4);
    if (long_hold > 0) begin
      out_chan.ready = 1'b0;
      long_hold--;
    end else if (mode == 0) begin
      out_chan.ready = 1'b1;
    end else if (mode == 1) begin
      out_chan.ready = ($urandom_range(0, 9) < 7);
    end else if (mode == 2) begin
      out_chan.ready = (($time / 8) % 5) != 0;
    end else begin
      out_chan.ready = ($urandom_range(0, 9) < 3);
    end
  end

  task automatic test_lookup_before_build();
    lookup(8'h00);
    lookup(8'hFF);
    lookup(8'h5A);
  endtask

  task automatic test_lone_symbol();
    add_byte(8'h07);
    add_byte(8'h07);
    add_byte(8'h07, 1'b1);
    lookup(8'h07);
    lookup(8'h08);
  endtask

  // Equal weights everywhere: every merge is decided by the key.
  task automatic test_tied_weights();
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(8'h01);
    add_byte(8'hFE, 1'b1);
    lookup(8'h00);
    lookup(8'hFF);
    lookup(8'h01);
    lookup(8'hFE);
    lookup(8'h80);
  endtask

  // Lookups keep the old table while the next message is counted.
  task automatic test_next_message();
    add_byte(8'h03);
    add_byte(8'h03);
    add_byte(8'h05, 1'b1);
    add_byte(8'h09);
    lookup(8'h03);
    lookup(8'h09);
    add_byte(8'h09, 1'b1);
    lookup(8'h09);
    lookup(8'h03);
  endtask

  // Hold the receiver off while lookups keep coming, so the block fills up.
  task automatic test_backpressure();
    drain_results();
    long_hold = 300;
    for (int i = 0; i < 30; i++) lookup(8'($urandom_range(0, 255)));
    drain_results();
  endtask

  // Random messages with random content, then lookups of the built table.
  task automatic test_random_messages(int item_goal);
    int sent;
    int n_sym;
    int len;
    int pick;
    logic [SYM_BITS-1:0] pool [ALPHABET];
    sent = 0;
    while (sent < item_goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) n_sym = $urandom_range(1, 8);
      else if (pick < 97) n_sym = $urandom_range(9, 40);
      else n_sym = $urandom_range(41, 256);
      for (int i = 0; i < n_sym; i++) pool[i] = 8'($urandom_range(0, 255));
      len = n_sym + $urandom_range(0, 2 * n_sym + 4);
      for (int i = 0; i < len; i++) begin
        // Occasional lookup in the middle of a message.
        if ($urandom_range(0, 19) == 0) begin
          lookup(8'($urandom_range(0, 255)));
          sent++;
        end
        add_byte(pool[$urandom_range(0, n_sym - 1)], i == len - 1);
        sent++;
      end
      repeat ($urandom_range(2, 10)) begin
        if ($urandom_range(0, 9) < 7) lookup(pool[$urandom_range(0, n_sym - 1)]);
        else lookup(8'($urandom_range(0, 255)));
        sent++;
      end
      if ($urandom_range(0, 15) == 0) drain_results();
    end
  endtask

  // Fibonacci weights give a skewed chain of ever longer codes in one build.
  task automatic test_skewed_tree();
    int fa;
    int fb;
    int fn;
    fa = 1;
    fb = 1;
    for (int s = 0; s < 10; s++) begin
      for (int n = 0; n < fa; n++) add_byte(8'(s * 13));
      fn = fa + fb;
      fa = fb;
      fb = fn;
    end
    add_byte(8'hC4, 1'b1);
    for (int s = 0; s < 10; s++) lookup(8'(s * 13));
    lookup(8'hC4);
    lookup(8'hFF);
    // The next message starts from an empty histogram.
    add_byte(8'h11);
    add_byte(8'h22, 1'b1);
    lookup(8'h11);
    lookup(8'h22);
  endtask

  // Test sequence.
  initial begin
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.op = OP_ADD;
    in_chan.symbol = '0;
    in_chan.last = 1'b0;
    out_chan.ready = 1'b0;
    foreach (hist_count[i]) hist_count[i] = 0;
    foreach (table_has[i]) table_has[i] = 1'b0;
    hist_total = 0;
    hist_exceeded = 1'b0;
    hist_clear_due = 1'b0;
    table_built = 1'b0;
    table_overflow_flag = 1'b0;
    pend_head = 0;
    pend_tail = 0;
    mismatch_count = 0;
    long_hold = 0;
    sender_gaps = 1'b1;
    burst_left = 0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    test_lookup_before_build();
    test_lone_symbol();
    test_tied_weights();
    test_next_message();
    test_backpressure();
    test_random_messages(1250);
    test_skewed_tree();

    drain_results();
    repeat (20) @(negedge clk);
    if (mismatch_count == 0 && pend_head == pend_tail) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
